// ===== sv/wsmh_pkg.sv =====
// ----------------------------------------------------------------------------
// wsmh_pkg
// Shared types, constants and mixing functions of the word stream hash.
// ----------------------------------------------------------------------------
package wsmh_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 3;

  localparam logic [WordW-1:0] MixC1   = 32'hCC9E2D51;
  localparam logic [WordW-1:0] MixC2   = 32'h1B873593;
  localparam logic [WordW-1:0] FoldAdd = 32'hE6546B64;
  localparam logic [WordW-1:0] FinM1   = 32'h85EBCA6B;
  localparam logic [WordW-1:0] FinM2   = 32'hC2B2AE35;

  // queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCountW = $clog2(QDepth + 1);

  // configuration register map (word index)
  localparam logic RegFinalize = 1'b0;

  // what the back end does with a queued word
  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,  // empty word, accumulator untouched
    KIND_LOAD = 2'd1,  // first non-empty word, taken unmixed
    KIND_FOLD = 2'd2   // later non-empty word, already pre-mixed
  } word_kind_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    word_kind_t       kind;
    logic             last;
  } q_item_t;

  typedef enum logic [1:0] {
    BK_RUN  = 2'd0,
    BK_MIX1 = 2'd1,
    BK_MIX2 = 2'd2,
    BK_LAST = 2'd3
  } back_state_t;

  function automatic logic [WordW-1:0] mask_word(input logic [WordW-1:0] w,
                                                  input logic [CountW-1:0] cnt);
    logic [WordW-1:0] m;
    begin
      unique case (cnt)
        3'd0:    m = 32'h0000_0000;
        3'd1:    m = 32'h0000_00FF;
        3'd2:    m = 32'h0000_FFFF;
        3'd3:    m = 32'h00FF_FFFF;
        default: m = 32'hFFFF_FFFF;
      endcase
      mask_word = w & m;
    end
  endfunction

  function automatic logic [WordW-1:0] rotr15(input logic [WordW-1:0] v);
    rotr15 = {v[14:0], v[WordW-1:15]};
  endfunction

  function automatic logic [WordW-1:0] rotr13(input logic [WordW-1:0] v);
    rotr13 = {v[12:0], v[WordW-1:13]};
  endfunction

endpackage

// ===== sv/wsmh_front.sv =====
// ----------------------------------------------------------------------------
// wsmh_front
// Takes input words, masks and classifies them, pre-mixes later words.
// ----------------------------------------------------------------------------
module wsmh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wsmh_pkg::WordW-1:0]    data_word,
  input  logic [wsmh_pkg::CountW-1:0]   byte_count,
  input  logic                          last_word,
  output logic                          q_push,
  output wsmh_pkg::q_item_t             q_item,
  input  logic                          q_ready
);

  logic                 seen;
  logic                 a_valid, b_valid, c_valid;
  wsmh_pkg::q_item_t    a_item, b_item, c_item;
  logic                 advance;
  logic                 take;
  wsmh_pkg::word_kind_t kind_in;

  // the whole pipe moves together; hold it only when the queue is full
  assign advance  = !c_valid || q_ready;
  assign in_ready = advance;
  assign take     = in_valid && advance;
  assign q_push   = c_valid && q_ready;
  assign q_item   = c_item;

  always_comb begin
    if (byte_count == '0) begin
      kind_in = wsmh_pkg::KIND_SKIP;
    end else if (seen) begin
      kind_in = wsmh_pkg::KIND_FOLD;
    end else begin
      kind_in = wsmh_pkg::KIND_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= 1'b0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (take) begin
        if (last_word) begin
          seen <= 1'b0;
        end else if (byte_count != '0) begin
          seen <= 1'b1;
        end
      end
      if (advance) begin
        a_valid <= in_valid;
        b_valid <= a_valid;
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_item.word <= wsmh_pkg::mask_word(data_word, byte_count);
      a_item.kind <= kind_in;
      a_item.last <= last_word;

      b_item <= a_item;
      if (a_item.kind == wsmh_pkg::KIND_FOLD) begin
        b_item.word <= a_item.word * wsmh_pkg::MixC1;
      end

      c_item <= b_item;
      if (b_item.kind == wsmh_pkg::KIND_FOLD) begin
        c_item.word <= wsmh_pkg::rotr15(b_item.word) * wsmh_pkg::MixC2;
      end
    end
  end

endmodule

// ===== sv/wsmh_fifo.sv =====
// ----------------------------------------------------------------------------
// wsmh_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module wsmh_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsmh_pkg::q_item_t push_item,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output wsmh_pkg::q_item_t pop_item
);

  wsmh_pkg::q_item_t                  slots [wsmh_pkg::QDepth];
  logic [wsmh_pkg::QAddrW-1:0]        wr_ptr, rd_ptr;
  logic [wsmh_pkg::QCountW-1:0]       count;

  assign push_ready = count != wsmh_pkg::QCountW'(wsmh_pkg::QDepth);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != wsmh_pkg::QCountW'(wsmh_pkg::QDepth)) || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

endmodule

// ===== sv/wsmh_back.sv =====
// ----------------------------------------------------------------------------
// wsmh_back
// Folds queued words into the accumulator and emits the finished hash.
// ----------------------------------------------------------------------------
module wsmh_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        finalize_enable,
  input  logic                        q_valid,
  input  wsmh_pkg::q_item_t           q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wsmh_pkg::WordW-1:0]  hash_value
);

  wsmh_pkg::back_state_t        state, state_next;
  logic [wsmh_pkg::WordW-1:0]   acc, acc_next;
  logic [wsmh_pkg::WordW-1:0]   h, h_next;
  logic [wsmh_pkg::WordW-1:0]   acc_new, rot;
  logic [wsmh_pkg::WordW-1:0]   out_data;
  logic                         out_load;
  logic                         out_free;

  assign out_free = !out_valid || out_ready;
  assign rot      = wsmh_pkg::rotr13(acc ^ q_item.word);

  always_comb begin
    unique case (q_item.kind)
      wsmh_pkg::KIND_LOAD: acc_new = q_item.word;
      wsmh_pkg::KIND_FOLD: acc_new = (rot << 2) + rot + wsmh_pkg::FoldAdd;
      default:             acc_new = acc;
    endcase
  end

  always_comb begin
    state_next = state;
    acc_next   = acc;
    h_next     = h;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    out_data   = h ^ (h >> 16);
    unique case (state)
      wsmh_pkg::BK_RUN: begin
        q_pop = q_valid && (!q_item.last || finalize_enable || out_free);
        if (q_pop) begin
          if (q_item.last) begin
            acc_next = '0;
            if (finalize_enable) begin
              h_next     = acc_new ^ (acc_new >> 16);
              state_next = wsmh_pkg::BK_MIX1;
            end else begin
              out_load = 1'b1;
              out_data = acc_new;
            end
          end else begin
            acc_next = acc_new;
          end
        end
      end
      wsmh_pkg::BK_MIX1: begin
        h_next     = h * wsmh_pkg::FinM1;
        state_next = wsmh_pkg::BK_MIX2;
      end
      wsmh_pkg::BK_MIX2: begin
        h_next     = (h ^ (h >> 13)) * wsmh_pkg::FinM2;
        state_next = wsmh_pkg::BK_LAST;
      end
      wsmh_pkg::BK_LAST: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = wsmh_pkg::BK_RUN;
        end
      end
      default: state_next = wsmh_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wsmh_pkg::BK_RUN;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h <= h_next;
    if (out_load) begin
      hash_value <= out_data;
    end
  end

  a_no_pop_in_finaliser: assert property (@(posedge clk) disable iff (rst)
    (state != wsmh_pkg::BK_RUN) |-> !q_pop)
    else $error("queue popped while finalising");

  a_load_takes_word: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_item.last && q_item.kind == wsmh_pkg::KIND_LOAD)
      |=> acc == $past(q_item.word))
    else $error("first word not loaded unmixed");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.last) |=> acc == '0)
    else $error("accumulator not cleared at end of buffer");

endmodule

// ===== sv/word_stream_mix_hash.sv =====
// ----------------------------------------------------------------------------
// word_stream_mix_hash
// Word stream hash (MurmurHash3 x86_32 style) with optional finaliser.
// ----------------------------------------------------------------------------
// A buffer arrives as 32-bit little-endian words, one transfer per word, each
// with its byte count and a last mark; bytes beyond the count are zeroed and a
// count above four counts as four. One hash_value transfer follows each last
// word. The front pipe takes one word per cycle while the queue has room and
// passes it through its a, b and c registers for masking and the two pre-mix
// multiplies; a four-entry queue then feeds the back end, which folds one word
// per cycle into the accumulator while it is not finalising or waiting for the
// output. A last word with finalize_enable set holds the back end in its MIX1,
// MIX2 and LAST states while the two finaliser multiplies run and the result
// waits for the output. An empty buffer hashes to zero.
// finalize_enable sits at byte address 0 of the APB port; write it only while
// no buffer is in flight.
// ----------------------------------------------------------------------------
module word_stream_mix_hash (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // word input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wsmh_pkg::WordW-1:0]    data_word,
  input  logic [wsmh_pkg::CountW-1:0]   byte_count,
  input  logic                          last_word,
  // hash output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wsmh_pkg::WordW-1:0]    hash_value
);

  logic              finalize_enable;
  logic              q_push, q_push_ready, q_pop, q_valid;
  wsmh_pkg::q_item_t q_in, q_out;

  // Single register, word index taken from paddr[2]; unaligned low bits drop.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      finalize_enable <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == wsmh_pkg::RegFinalize)) begin
      finalize_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == wsmh_pkg::RegFinalize) begin
      prdata[0] = finalize_enable;
    end
  end

  // Front: mask, classify first/later/empty words, pre-mix later words.
  wsmh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .q_push     (q_push),
    .q_item     (q_in),
    .q_ready    (q_push_ready)
  );

  // Queue: let the front keep taking words while the back finalises.
  wsmh_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out)
  );

  // Back: fold into the accumulator, finalise and hold the result register.
  wsmh_back u_back (
    .clk             (clk),
    .rst             (rst),
    .finalize_enable (finalize_enable),
    .q_valid         (q_valid),
    .q_item          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .hash_value      (hash_value)
  );

endmodule
